>>> hdl/rdt_pkg.sv
`default_nettype none

package rdt_pkg;

  // most result words one command may produce
  localparam int MAX_RESULTS = 32;
  // counter width able to hold MAX_RESULTS
  localparam int RW = $clog2(MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    MODE_SEND    = 3'd0,
    MODE_RECV    = 3'd1,
    MODE_ACK     = 3'd2,
    MODE_TIMEOUT = 3'd3,
    MODE_DRAIN   = 3'd4,
    MODE_CLEAR   = 3'd5
  } mode_t;

  typedef enum logic [3:0] {
    EV_ASSIGNED = 4'd0,
    EV_ACCEPTED = 4'd1,
    EV_STALE    = 4'd2,
    EV_SUCCESS  = 4'd3,
    EV_UNKNOWN  = 4'd4,
    EV_FAILURE  = 4'd5,
    EV_ACK_OUT  = 4'd6,
    EV_NONE     = 4'd7,
    EV_CLEARED  = 4'd8
  } evt_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] seq_in;
    logic [31:0] now_ms;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  event_kind;
    logic [31:0] seq_out;
    logic        overflow;
    logic        acks_waiting;
    logic        last;
  } evt_t;

  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] sent_at;
  } pend_entry_t;

  typedef struct packed {
    logic match;
    logic expired;
  } cmp_res_t;

endpackage

`default_nettype wire

>>> hdl/reliable_delivery_tracker.sv
`default_nettype none

// Reliable delivery tracker. Commands come in as cmd words (send, receive,
// ack, timeout check, drain, clear) and each one gives one or more evt words,
// the final one marked by last. The block takes one command at a time:
// cmd_ready is high only while it is idle. Send, receive, clear and unused
// modes finish in the execute state when the output is free. Ack and timeout
// check walk the pending table once, compacting it, one entry per cycle
// through the single pending table read port and the shared age/match
// compare unit while no failure word waits on the output. A drain reads
// the ack queue a word per cycle through its read port when output is free.
// The timeout register is written through the cfg port at any time the block
// is idle and is not touched by clear. No clearing pass follows reset.
module reliable_delivery_tracker
  import rdt_pkg::*;
#(
  parameter int PENDING_DEPTH = 32,
  parameter int ACK_DEPTH     = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  output logic             cmd_ready,
  input  wire cmd_t        cmd,
  output logic             evt_valid,
  input  wire logic        evt_ready,
  output evt_t             evt,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  // pending table address and count widths
  localparam int PAW = $clog2(PENDING_DEPTH);
  localparam int PCW = $clog2(PENDING_DEPTH + 1);
  // ack queue address and count widths
  localparam int AAW = $clog2(ACK_DEPTH);
  localparam int ACW = $clog2(ACK_DEPTH + 1);
  // width for head + count before wrap
  localparam int ASW = AAW + 1;

  // sequencer state
  state_t      state, state_next;
  cmd_t        cmd_q, cmd_q_next;

  // architectural state
  logic [31:0] timeout_ms;
  logic [31:0] next_send_seq, next_send_seq_next;
  logic [31:0] expected_recv_seq, expected_recv_seq_next;
  logic [PCW-1:0] pend_count, pend_count_next;
  logic [ACW-1:0] ack_count, ack_count_next;
  logic [AAW-1:0] ack_head, ack_head_next;

  // scan bookkeeping
  logic [PCW-1:0] scan_rd, scan_rd_next;
  logic [PCW-1:0] scan_wr, scan_wr_next;
  logic           found, found_next;
  logic [RW-1:0]  nfail, nfail_next;
  logic           dv, dv_next;
  logic           hold_valid, hold_valid_next;
  logic [31:0]    hold_seq, hold_seq_next;

  // drain bookkeeping
  logic [RW-1:0]  take, take_next;
  logic [RW-1:0]  drain_rd, drain_rd_next;
  logic [RW-1:0]  drain_out, drain_out_next;

  // output register
  logic evt_valid_next;
  evt_t evt_next;

  // memory ports
  logic           p_we, p_re;
  logic [PAW-1:0] p_waddr, p_raddr;
  pend_entry_t    p_wdata, pend_rdata;
  logic           a_we, a_re;
  logic [AAW-1:0] a_waddr, a_raddr;
  logic [31:0]    a_wdata, ack_rdata;

  cmp_res_t cmp_res;

  // helper terms
  logic           out_free;
  logic           acks_nz;
  logic           pend_full;
  logic           ack_full;
  logic [ASW-1:0] tail_sum;
  logic [AAW-1:0] ack_tail;
  logic [AAW-1:0] head_inc;
  logic [RW-1:0]  take_calc;
  logic           is_timeout;
  logic           emits;
  logic           drop_ack;
  logic           proc_ok;
  logic           emit_ok;

  assign cfg_ready = 1'b1;
  assign cmd_ready = (state == ST_IDLE);

  assign out_free  = !evt_valid || evt_ready;
  assign acks_nz   = (ack_count != '0);
  assign pend_full = (pend_count == PCW'(PENDING_DEPTH));
  assign ack_full  = (ack_count == ACW'(ACK_DEPTH));

  // circular ack queue: tail is head + count, wrapped
  assign tail_sum = ASW'(ack_head) + ASW'(ack_count);
  assign ack_tail = (tail_sum >= ASW'(ACK_DEPTH)) ?
                    AAW'(tail_sum - ASW'(ACK_DEPTH)) : AAW'(tail_sum);
  assign head_inc = (ack_head == AAW'(ACK_DEPTH - 1)) ? '0 : ack_head + AAW'(1);

  // a drain hands out at most MAX_RESULTS words
  assign take_calc = (32'(ack_count) >= 32'(MAX_RESULTS)) ?
                     RW'(MAX_RESULTS) : RW'(ack_count);

  // scan decisions for the entry now at the table read port
  assign is_timeout = (cmd_q.mode == MODE_TIMEOUT);
  assign emits      = is_timeout && cmp_res.expired && (nfail < RW'(MAX_RESULTS));
  assign drop_ack   = !is_timeout && cmp_res.match && !found;
  // a new failure with one already held needs the output register
  assign proc_ok    = dv && (!emits || !hold_valid || out_free);
  assign emit_ok    = dv && out_free;

  rdt_ram #(
    .WIDTH($bits(pend_entry_t)),
    .DEPTH(PENDING_DEPTH)
  ) u_pend_ram (
    .clk  (clk),
    .we   (p_we),
    .waddr(p_waddr),
    .wdata(p_wdata),
    .re   (p_re),
    .raddr(p_raddr),
    .rdata(pend_rdata)
  );

  rdt_ram #(
    .WIDTH(32),
    .DEPTH(ACK_DEPTH)
  ) u_ack_ram (
    .clk  (clk),
    .we   (a_we),
    .waddr(a_waddr),
    .wdata(a_wdata),
    .re   (a_re),
    .raddr(a_raddr),
    .rdata(ack_rdata)
  );

  // shared compare unit: sequence match and age check
  rdt_cmp u_cmp (
    .entry     (pend_rdata),
    .key       (cmd_q.seq_in),
    .now_ms    (cmd_q.now_ms),
    .timeout_ms(timeout_ms),
    .res       (cmp_res)
  );

  function automatic evt_t make_evt(evt_kind_t kind, logic [31:0] seq, logic ovf,
                                    logic aw, logic lst);
    evt_t e;
    e.event_kind   = kind;
    e.seq_out      = seq;
    e.overflow     = ovf;
    e.acks_waiting = aw;
    e.last         = lst;
    return e;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      timeout_ms        <= 32'd1000;
      next_send_seq     <= '0;
      expected_recv_seq <= '0;
      pend_count        <= '0;
      ack_count         <= '0;
      ack_head          <= '0;
      evt_valid         <= 1'b0;
      dv                <= 1'b0;
      hold_valid        <= 1'b0;
    end else begin
      state             <= state_next;
      next_send_seq     <= next_send_seq_next;
      expected_recv_seq <= expected_recv_seq_next;
      pend_count        <= pend_count_next;
      ack_count         <= ack_count_next;
      ack_head          <= ack_head_next;
      evt_valid         <= evt_valid_next;
      dv                <= dv_next;
      hold_valid        <= hold_valid_next;
      if (cfg_valid && cfg_ready) begin
        timeout_ms <= cfg_data;
      end
    end
  end

  // payload and scan counters, set before each use
  always_ff @(posedge clk) begin
    cmd_q     <= cmd_q_next;
    evt       <= evt_next;
    scan_rd   <= scan_rd_next;
    scan_wr   <= scan_wr_next;
    found     <= found_next;
    nfail     <= nfail_next;
    hold_seq  <= hold_seq_next;
    take      <= take_next;
    drain_rd  <= drain_rd_next;
    drain_out <= drain_out_next;
  end

  always_comb begin
    state_next             = state;
    cmd_q_next             = cmd_q;
    next_send_seq_next     = next_send_seq;
    expected_recv_seq_next = expected_recv_seq;
    pend_count_next        = pend_count;
    ack_count_next         = ack_count;
    ack_head_next          = ack_head;
    scan_rd_next           = scan_rd;
    scan_wr_next           = scan_wr;
    found_next             = found;
    nfail_next             = nfail;
    dv_next                = dv;
    hold_valid_next        = hold_valid;
    hold_seq_next          = hold_seq;
    take_next              = take;
    drain_rd_next          = drain_rd;
    drain_out_next         = drain_out;
    // word leaves when taken
    evt_valid_next         = evt_valid && !evt_ready;
    evt_next               = evt;
    p_we    = 1'b0;
    p_waddr = '0;
    p_wdata = '0;
    p_re    = 1'b0;
    p_raddr = '0;
    a_we    = 1'b0;
    a_waddr = '0;
    a_wdata = '0;
    a_re    = 1'b0;
    a_raddr = '0;

    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_q_next = cmd;
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        unique case (cmd_q.mode) inside
          MODE_SEND: begin
            if (out_free) begin
              // sequence number is used up even when the table is full
              next_send_seq_next = next_send_seq + 32'd1;
              if (!pend_full) begin
                p_we            = 1'b1;
                p_waddr         = pend_count[PAW-1:0];
                p_wdata.seq     = next_send_seq;
                p_wdata.sent_at = cmd_q.now_ms;
                pend_count_next = pend_count + PCW'(1);
              end
              evt_valid_next = 1'b1;
              evt_next = make_evt(EV_ASSIGNED, next_send_seq, pend_full, acks_nz, 1'b1);
              state_next = ST_IDLE;
            end
          end

          MODE_RECV: begin
            if (out_free) begin
              evt_valid_next = 1'b1;
              if (cmd_q.seq_in >= expected_recv_seq) begin
                expected_recv_seq_next = cmd_q.seq_in + 32'd1;
                if (!ack_full) begin
                  a_we           = 1'b1;
                  a_waddr        = ack_tail;
                  a_wdata        = cmd_q.seq_in;
                  ack_count_next = ack_count + ACW'(1);
                end
                // queue is nonempty whether or not this one fit
                evt_next = make_evt(EV_ACCEPTED, cmd_q.seq_in, ack_full, 1'b1, 1'b1);
              end else begin
                evt_next = make_evt(EV_STALE, cmd_q.seq_in, 1'b0, acks_nz, 1'b1);
              end
              state_next = ST_IDLE;
            end
          end

          MODE_ACK, MODE_TIMEOUT: begin
            scan_rd_next    = '0;
            scan_wr_next    = '0;
            found_next      = 1'b0;
            nfail_next      = '0;
            dv_next         = 1'b0;
            hold_valid_next = 1'b0;
            state_next      = ST_SCAN;
          end

          MODE_DRAIN: begin
            take_next      = take_calc;
            ack_count_next = ack_count - ACW'(take_calc);
            drain_rd_next  = '0;
            drain_out_next = '0;
            dv_next        = 1'b0;
            state_next     = (take_calc == '0) ? ST_FINISH : ST_DRAIN;
          end

          MODE_CLEAR: begin
            if (out_free) begin
              next_send_seq_next     = '0;
              expected_recv_seq_next = '0;
              pend_count_next        = '0;
              ack_count_next         = '0;
              ack_head_next          = '0;
              evt_valid_next         = 1'b1;
              evt_next   = make_evt(EV_CLEARED, 32'd0, 1'b0, 1'b0, 1'b1);
              state_next = ST_IDLE;
            end
          end

          default: begin
            // unused modes
            if (out_free) begin
              evt_valid_next = 1'b1;
              evt_next   = make_evt(EV_NONE, 32'd0, 1'b0, acks_nz, 1'b1);
              state_next = ST_IDLE;
            end
          end
        endcase
      end

      ST_SCAN: begin
        // retire the entry at the read port: report, drop or compact
        if (proc_ok) begin
          if (emits) begin
            // held failure is not the final one
            if (hold_valid) begin
              evt_valid_next = 1'b1;
              evt_next = make_evt(EV_FAILURE, hold_seq, 1'b0, acks_nz, 1'b0);
            end
            hold_valid_next = 1'b1;
            hold_seq_next   = pend_rdata.seq;
            nfail_next      = nfail + RW'(1);
          end else if (drop_ack) begin
            found_next = 1'b1;
          end else begin
            p_we         = 1'b1;
            p_waddr      = scan_wr[PAW-1:0];
            p_wdata      = pend_rdata;
            scan_wr_next = scan_wr + PCW'(1);
          end
        end
        // fetch the next entry; writes trail reads so no hazard
        if (!dv || proc_ok) begin
          if (scan_rd < pend_count) begin
            p_re         = 1'b1;
            p_raddr      = scan_rd[PAW-1:0];
            scan_rd_next = scan_rd + PCW'(1);
            dv_next      = 1'b1;
          end else begin
            dv_next = 1'b0;
          end
        end
        if (!dv && (scan_rd == pend_count)) begin
          pend_count_next = scan_wr;
          state_next      = ST_FINISH;
        end
      end

      ST_DRAIN: begin
        if (emit_ok) begin
          evt_valid_next = 1'b1;
          evt_next = make_evt(EV_ACK_OUT, ack_rdata, 1'b0, acks_nz,
                              drain_out == take - RW'(1));
          drain_out_next = drain_out + RW'(1);
          if (drain_out == take - RW'(1)) begin
            state_next = ST_IDLE;
          end
        end
        if (!dv || emit_ok) begin
          if (drain_rd < take) begin
            a_re          = 1'b1;
            a_raddr       = ack_head;
            ack_head_next = head_inc;
            drain_rd_next = drain_rd + RW'(1);
            dv_next       = 1'b1;
          end else begin
            dv_next = 1'b0;
          end
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          evt_valid_next = 1'b1;
          if (cmd_q.mode == MODE_ACK) begin
            evt_next = make_evt(found ? EV_SUCCESS : EV_UNKNOWN, cmd_q.seq_in,
                                1'b0, acks_nz, 1'b1);
          end else if (is_timeout && hold_valid) begin
            // last failure of the check
            evt_next        = make_evt(EV_FAILURE, hold_seq, 1'b0, acks_nz, 1'b1);
            hold_valid_next = 1'b0;
          end else begin
            // nothing expired, or empty drain
            evt_next = make_evt(EV_NONE, 32'd0, 1'b0, acks_nz, 1'b1);
          end
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // table and queue never run past their depth
  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pend_count <= PCW'(PENDING_DEPTH))
    else $error("pending count beyond table depth");

  a_ack_bound: assert property (@(posedge clk) disable iff (rst)
    ack_count <= ACW'(ACK_DEPTH))
    else $error("ack count beyond queue depth");

  // a held failure is always flushed before the next command
  a_hold_flushed: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !hold_valid)
    else $error("failure word left behind at end of check");

  // a timeout check never reports more than the result limit
  a_fail_limit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (nfail <= RW'(MAX_RESULTS)))
    else $error("too many failures in one check");

  // a scan only finishes once every entry has been read and retired
  a_scan_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && state_next == ST_FINISH) |-> (!dv && scan_rd == pend_count))
    else $error("scan left entries unvisited");
`endif

endmodule

`default_nettype wire

>>> hdl/rdt_ram.sv
`default_nettype none

module rdt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/rdt_cmp.sv
`default_nettype none

module rdt_cmp
  import rdt_pkg::*;
(
  input  wire pend_entry_t entry,
  input  wire logic [31:0] key,
  input  wire logic [31:0] now_ms,
  input  wire logic [31:0] timeout_ms,
  output cmp_res_t         res
);

  logic [31:0] age;

  // wrapping age of the entry
  assign age         = now_ms - entry.sent_at;
  assign res.expired = age > timeout_ms;
  assign res.match   = entry.seq == key;

endmodule

`default_nettype wire
